// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL; clk and rst_n must exist in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/pib_pkg.sv =====
package pib_pkg;

  // Index width register and its legal range.
  localparam int BPI_W   = 4;
  localparam int BPI_MIN = 1;
  localparam int BPI_MAX = 12;
  localparam int BPI_RST = 12;

  // Width of a capacity value (up to two to BPI_MAX).
  localparam int CAP_W = BPI_MAX + 1;

  // Fixed port widths.
  localparam int PIX_W = 12;
  localparam int IDX_W = 12;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } pib_state_t;

  typedef struct packed {
    logic load;       // capture a new item, restart scan
    logic step;       // advance the palette scan by one entry
    logic emit_hit;   // report the entry found by the scan
    logic emit_miss;  // append the color or report overflow
  } pib_cmd_t;

  typedef struct packed {
    logic hit;        // registered read matches the item color
    logic miss;       // all stored entries checked, no match
  } pib_status_t;

endpackage

// ===== hw/rtl/pib_ctrl.sv =====
`include "assert_macros.svh"

module pib_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  pib_pkg::pib_status_t status_i,
  output pib_pkg::pib_cmd_t   cmd_o,
  output logic                busy_o
);

  pib_pkg::pib_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pib_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    busy_o    = 1'b0;
    unique case (state_r)
      pib_pkg::ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_nxt  = pib_pkg::ST_SCAN;
        end
      end
      pib_pkg::ST_SCAN: begin
        busy_o     = 1'b1;
        cmd_o.step = 1'b1;
        priority if (status_i.hit) begin
          cmd_o.emit_hit = 1'b1;
          state_nxt      = pib_pkg::ST_IDLE;
        end else if (status_i.miss) begin
          cmd_o.emit_miss = 1'b1;
          state_nxt       = pib_pkg::ST_IDLE;
        end else begin
          // keep scanning
          state_nxt = pib_pkg::ST_SCAN;
        end
      end
      default: begin
        state_nxt = pib_pkg::ST_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_busy_needs_start, $rose(busy_o) |-> $past(start_i), "scan began without start")
  `ASSERT_CLK(a_emit_ends_scan, (cmd_o.emit_hit || cmd_o.emit_miss) |=> !busy_o, "busy after result")

endmodule

// ===== hw/rtl/pib_datapath.sv =====
`include "assert_macros.svh"

module pib_datapath #(
  parameter int MAX_ENTRIES = 4096,
  parameter int COLOR_WIDTH = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pib_pkg::pib_cmd_t          cmd_i,
  output pib_pkg::pib_status_t       status_o,
  input  logic [pib_pkg::PIX_W-1:0]  pixel_color_i,
  input  logic                       cfg_we_i,
  input  logic [pib_pkg::BPI_W-1:0]  cfg_wdata_i,
  output logic                       out_valid_o,
  output logic [pib_pkg::IDX_W-1:0]  out_palette_index_o,
  output logic                       out_is_new_color_o,
  output logic                       out_overflow_o
);

  // Only the low bits of the port that fit COLOR_WIDTH take part.
  localparam int CW   = (COLOR_WIDTH < pib_pkg::PIX_W) ? COLOR_WIDTH : pib_pkg::PIX_W;
  localparam int AW   = $clog2(MAX_ENTRIES);
  localparam int CNTW = $clog2(MAX_ENTRIES + 1);

  logic [CW-1:0]             mem [MAX_ENTRIES];

  logic [pib_pkg::BPI_W-1:0] bpi_r;
  logic [CNTW-1:0]           count_r;
  logic [CNTW-1:0]           addr_r;
  logic [CW-1:0]             color_r;
  logic [CW-1:0]             rd_data_r;
  logic [AW-1:0]             rd_idx_r;
  logic                      rd_vld_r;

  logic                      out_valid_r;
  logic [pib_pkg::IDX_W-1:0] out_idx_r;
  logic                      out_new_r;
  logic                      out_ovf_r;

  logic [pib_pkg::BPI_W-1:0] bpi_eff;
  logic [pib_pkg::CAP_W-1:0] cap;
  logic                      full;
  logic                      scan_more;

  // Capacity: two to the clamped index width, bounded by the memory depth.
  always_comb begin
    bpi_eff = bpi_r;
    if (bpi_r < pib_pkg::BPI_W'(pib_pkg::BPI_MIN)) begin
      bpi_eff = pib_pkg::BPI_W'(pib_pkg::BPI_MIN);
    end else if (bpi_r > pib_pkg::BPI_W'(pib_pkg::BPI_MAX)) begin
      bpi_eff = pib_pkg::BPI_W'(pib_pkg::BPI_MAX);
    end
    cap = pib_pkg::CAP_W'(1) << bpi_eff;
    if (cap > pib_pkg::CAP_W'(MAX_ENTRIES)) begin
      cap = pib_pkg::CAP_W'(MAX_ENTRIES);
    end
  end

  assign full      = pib_pkg::CAP_W'(count_r) >= cap;
  assign scan_more = addr_r < count_r;

  assign status_o.hit  = rd_vld_r && (rd_data_r == color_r);
  assign status_o.miss = !scan_more && !rd_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpi_r <= pib_pkg::BPI_W'(pib_pkg::BPI_RST);
    end else if (cfg_we_i) begin
      bpi_r <= cfg_wdata_i;
    end
  end

  // Scan: one read issued per cycle, its data compared against the item in the following cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      addr_r   <= '0;
    end else if (cmd_i.load) begin
      rd_vld_r <= 1'b0;
      addr_r   <= '0;
    end else if (cmd_i.step) begin
      if (scan_more) begin
        rd_vld_r <= 1'b1;
        addr_r   <= addr_r + CNTW'(1);
      end else begin
        rd_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      color_r <= pixel_color_i[CW-1:0];
    end
    if (cmd_i.step && scan_more) begin
      rd_idx_r <= addr_r[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.step) begin
      rd_data_r <= mem[addr_r[AW-1:0]];
    end
    if (cmd_i.emit_miss && !full) begin
      mem[count_r[AW-1:0]] <= color_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd_i.emit_miss && !full) begin
      count_r <= count_r + CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.emit_hit || cmd_i.emit_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.emit_hit) begin
      out_idx_r <= pib_pkg::IDX_W'(rd_idx_r);
      out_new_r <= 1'b0;
      out_ovf_r <= 1'b0;
    end else if (cmd_i.emit_miss) begin
      if (full) begin
        out_idx_r <= '0;
        out_new_r <= 1'b0;
        out_ovf_r <= 1'b1;
      end else begin
        out_idx_r <= pib_pkg::IDX_W'(count_r);
        out_new_r <= 1'b1;
        out_ovf_r <= 1'b0;
      end
    end
  end

  assign out_valid_o         = out_valid_r;
  assign out_palette_index_o = out_idx_r;
  assign out_is_new_color_o  = out_new_r;
  assign out_overflow_o      = out_ovf_r;

  `ASSERT_CLK(a_count_bound, count_r <= CNTW'(MAX_ENTRIES), "count past depth")
  `ASSERT_CLK(a_new_bumps_count, (out_valid_r && out_new_r) |-> (count_r == $past(count_r) + CNTW'(1)), "no count bump")
  `ASSERT_CLK(a_ovf_result, (out_valid_r && out_ovf_r) |-> (!out_new_r && (out_idx_r == '0) && $stable(count_r)), "bad overflow")

endmodule

// ===== hw/rtl/palette_index_builder.sv =====
// Palette index builder: maps each 12-bit pixel color to an index in a
// palette that grows in first-seen order.
// Input: an item is taken at a clock edge with start high and busy low.
// Result: out_valid is high for one cycle with out_palette_index,
// out_is_new_color and out_overflow; the receiver cannot stall, so every
// result must be captured in that cycle.
// Config: cfg_we with cfg_wdata sets the index width (capacity two to that
// power, clamped to 1..12 and to MAX_ENTRIES); write it only while idle.
// Scan: with N entries stored, a color found at index k keeps busy high
// while entries 0 to k are read and compared, a new color (appended or
// overflowing) while all N entries are; an empty palette misses at once.
// The result strobe comes in the first cycle with busy low, and a new item
// may be started in that same cycle. A new item is thus taken only after
// the last one is through, since the palette memory is scanned one entry
// per cycle through its single read port.
// Reset: empties the palette and sets the index width to 12; no clearing
// pass is needed, stored entries past the fill count are never used.
module palette_index_builder #(
  parameter int MAX_ENTRIES = 4096,
  parameter int COLOR_WIDTH = 12
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [pib_pkg::PIX_W-1:0]  in_pixel_color,
  output logic                       out_valid,
  output logic [pib_pkg::IDX_W-1:0]  out_palette_index,
  output logic                       out_is_new_color,
  output logic                       out_overflow,
  input  logic                       cfg_we,
  input  logic [pib_pkg::BPI_W-1:0]  cfg_wdata
);

  pib_pkg::pib_cmd_t    cmd;
  pib_pkg::pib_status_t status;

  pib_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  pib_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .COLOR_WIDTH (COLOR_WIDTH)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_i               (cmd),
    .status_o            (status),
    .pixel_color_i       (in_pixel_color),
    .cfg_we_i            (cfg_we),
    .cfg_wdata_i         (cfg_wdata),
    .out_valid_o         (out_valid),
    .out_palette_index_o (out_palette_index),
    .out_is_new_color_o  (out_is_new_color),
    .out_overflow_o      (out_overflow)
  );

endmodule
